FILE: rtl/core/csc_pkg.sv
// Shared types, constants and the microcode program of the calibrated step counter.
// Used by every module and interface of the block; depends on nothing else.
`default_nettype none

package csc_pkg;

	// Sample and magnitude widths
	localparam int ACCEL_BITS     = 16;
	localparam int MUL_W          = ACCEL_BITS + 1;
	localparam int PROD_W         = 2 * ACCEL_BITS;
	localparam int RAD_W          = 2 * ACCEL_BITS;
	localparam int ROOT_W         = ACCEL_BITS;
	localparam int COUNT_W        = 16;
	localparam int MAG_MAX        = 46340;
	localparam int MAX_WINDOW_DEF = 64;

	localparam logic signed [ACCEL_BITS-1:0] ACCEL_POS_MAX = {1'b0, {(ACCEL_BITS-1){1'b1}}};
	localparam logic signed [ACCEL_BITS-1:0] ACCEL_NEG_MAX = {1'b1, {(ACCEL_BITS-1){1'b0}}};

	// Configuration port
	localparam int CAL_W      = 16;
	localparam int WL_W       = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 1'b1;

	localparam logic [CAL_W-1:0] CAL_SAMPLES_RST = 16'd500;
	localparam logic [WL_W-1:0]  WINDOW_LEN_RST  = 7'd25;

	// Multiplier operand select
	localparam logic [2:0] MS_NONE = 3'd0;
	localparam logic [2:0] MS_X    = 3'd1;
	localparam logic [2:0] MS_Y    = 3'd2;
	localparam logic [2:0] MS_MINX = 3'd3;
	localparam logic [2:0] MS_MINY = 3'd4;
	localparam logic [2:0] MS_MAXX = 3'd5;
	localparam logic [2:0] MS_MAXY = 3'd6;
	localparam logic [2:0] MS_THR  = 3'd7;

	// Accumulator operation
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// Datapath action
	localparam logic [2:0] ACT_NOP     = 3'd0;
	localparam logic [2:0] ACT_TRACK   = 3'd1;
	localparam logic [2:0] ACT_SQRT    = 3'd2;
	localparam logic [2:0] ACT_SAVE_LO = 3'd3;
	localparam logic [2:0] ACT_SET_THR = 3'd4;
	localparam logic [2:0] ACT_WIN_ADD = 3'd5;
	localparam logic [2:0] ACT_DECIDE  = 3'd6;
	localparam logic [2:0] ACT_EMIT    = 3'd7;

	// Jump conditions
	localparam logic [2:0] CND_NEVER     = 3'd0;
	localparam logic [2:0] CND_ALWAYS    = 3'd1;
	localparam logic [2:0] CND_NO_ITEM   = 3'd2;
	localparam logic [2:0] CND_RUNNING   = 3'd3;
	localparam logic [2:0] CND_CAL_OPEN  = 3'd4;
	localparam logic [2:0] CND_SQRT_BUSY = 3'd5;
	localparam logic [2:0] CND_WIN_OPEN  = 3'd6;
	localparam logic [2:0] CND_OUT_FULL  = 3'd7;

	// Program addresses; fall-through goes to the next address
	localparam int UPC_W = 5;
	localparam logic [UPC_W-1:0] UA_IDLE      = 5'd0;
	localparam logic [UPC_W-1:0] UA_DISPATCH  = 5'd1;
	localparam logic [UPC_W-1:0] UA_TRACK     = 5'd2;
	localparam logic [UPC_W-1:0] UA_CAL_CHECK = 5'd3;
	localparam logic [UPC_W-1:0] UA_LO_MULX   = 5'd4;
	localparam logic [UPC_W-1:0] UA_LO_MULY   = 5'd5;
	localparam logic [UPC_W-1:0] UA_LO_SUM    = 5'd6;
	localparam logic [UPC_W-1:0] UA_LO_SQRT   = 5'd7;
	localparam logic [UPC_W-1:0] UA_LO_WAIT   = 5'd8;
	localparam logic [UPC_W-1:0] UA_HI_MULX   = 5'd9;
	localparam logic [UPC_W-1:0] UA_HI_MULY   = 5'd10;
	localparam logic [UPC_W-1:0] UA_HI_SUM    = 5'd11;
	localparam logic [UPC_W-1:0] UA_HI_SQRT   = 5'd12;
	localparam logic [UPC_W-1:0] UA_HI_WAIT   = 5'd13;
	localparam logic [UPC_W-1:0] UA_SET_THR   = 5'd14;
	localparam logic [UPC_W-1:0] UA_MAG_MULX  = 5'd15;
	localparam logic [UPC_W-1:0] UA_MAG_MULY  = 5'd16;
	localparam logic [UPC_W-1:0] UA_MAG_SUM   = 5'd17;
	localparam logic [UPC_W-1:0] UA_MAG_SQRT  = 5'd18;
	localparam logic [UPC_W-1:0] UA_MAG_WAIT  = 5'd19;
	localparam logic [UPC_W-1:0] UA_WIN_ADD   = 5'd20;
	localparam logic [UPC_W-1:0] UA_WIN_CHECK = 5'd21;
	localparam logic [UPC_W-1:0] UA_DECIDE    = 5'd22;
	localparam logic [UPC_W-1:0] UA_EMIT      = 5'd31;

	typedef struct packed {
		logic [2:0]       mul_sel;
		logic [1:0]       acc_op;
		logic [2:0]       act;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic item_valid;
		logic running;
		logic cal_open;
		logic sqrt_busy;
		logic win_open;
		logic out_full;
	} seq_stat_t;

	function automatic ucode_t uc(input logic [2:0] ms, input logic [1:0] ao,
			input logic [2:0] ac, input logic [2:0] cn, input logic [UPC_W-1:0] tg);
		ucode_t w;
		w.mul_sel = ms;
		w.acc_op  = ao;
		w.act     = ac;
		w.cond    = cn;
		w.target  = tg;
		return w;
	endfunction

	// Control store: one word per step
	function automatic ucode_t csc_ucode(input logic [UPC_W-1:0] addr);
		ucode_t w;
		case (addr)
			UA_IDLE:      w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_NO_ITEM,   UA_IDLE);
			UA_DISPATCH:  w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_RUNNING,   UA_MAG_MULX);
			UA_TRACK:     w = uc(MS_NONE, ACC_HOLD, ACT_TRACK,   CND_NEVER,     UA_IDLE);
			UA_CAL_CHECK: w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_CAL_OPEN,  UA_EMIT);
			UA_LO_MULX:   w = uc(MS_MINX, ACC_HOLD, ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_LO_MULY:   w = uc(MS_MINY, ACC_LOAD, ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_LO_SUM:    w = uc(MS_NONE, ACC_ADD,  ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_LO_SQRT:   w = uc(MS_NONE, ACC_HOLD, ACT_SQRT,    CND_NEVER,     UA_IDLE);
			UA_LO_WAIT:   w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_SQRT_BUSY, UA_LO_WAIT);
			UA_HI_MULX:   w = uc(MS_MAXX, ACC_HOLD, ACT_SAVE_LO, CND_NEVER,     UA_IDLE);
			UA_HI_MULY:   w = uc(MS_MAXY, ACC_LOAD, ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_HI_SUM:    w = uc(MS_NONE, ACC_ADD,  ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_HI_SQRT:   w = uc(MS_NONE, ACC_HOLD, ACT_SQRT,    CND_NEVER,     UA_IDLE);
			UA_HI_WAIT:   w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_SQRT_BUSY, UA_HI_WAIT);
			UA_SET_THR:   w = uc(MS_NONE, ACC_HOLD, ACT_SET_THR, CND_ALWAYS,    UA_EMIT);
			UA_MAG_MULX:  w = uc(MS_X,    ACC_HOLD, ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_MAG_MULY:  w = uc(MS_Y,    ACC_LOAD, ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_MAG_SUM:   w = uc(MS_NONE, ACC_ADD,  ACT_NOP,     CND_NEVER,     UA_IDLE);
			UA_MAG_SQRT:  w = uc(MS_NONE, ACC_HOLD, ACT_SQRT,    CND_NEVER,     UA_IDLE);
			UA_MAG_WAIT:  w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_SQRT_BUSY, UA_MAG_WAIT);
			UA_WIN_ADD:   w = uc(MS_THR,  ACC_HOLD, ACT_WIN_ADD, CND_NEVER,     UA_IDLE);
			UA_WIN_CHECK: w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_WIN_OPEN,  UA_EMIT);
			UA_DECIDE:    w = uc(MS_NONE, ACC_HOLD, ACT_DECIDE,  CND_ALWAYS,    UA_EMIT);
			UA_EMIT:      w = uc(MS_NONE, ACC_HOLD, ACT_EMIT,    CND_OUT_FULL,  UA_EMIT);
			default:      w = uc(MS_NONE, ACC_HOLD, ACT_NOP,     CND_ALWAYS,    UA_IDLE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/csc_sample_if.sv
// Input channel of the step counter: one X/Y accelerometer sample per item.
// Depends on csc_pkg for the sample width.
`default_nettype none

interface csc_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [csc_pkg::ACCEL_BITS-1:0] accel_x;
	logic signed [csc_pkg::ACCEL_BITS-1:0] accel_y;

	modport source (output valid, output accel_x, output accel_y, input ready);
	modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/csc_result_if.sv
// Output channel of the step counter: one result item per sample.
// Depends on csc_pkg for the field widths.
`default_nettype none

interface csc_result_if;
	logic                           valid;
	logic                           ready;
	logic [csc_pkg::COUNT_W-1:0]    step_count;
	logic                           step_taken;
	logic                           calibrating;
	logic [csc_pkg::ROOT_W-1:0]     threshold;

	modport source (output valid, output step_count, output step_taken,
		output calibrating, output threshold, input ready);
	modport sink   (input valid, input step_count, input step_taken,
		input calibrating, input threshold, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/csc_sqrt.sv
// Iterative integer square root, one result bit per cycle (floored root).
// Depends on csc_pkg for the radicand and root widths.
`default_nettype none

module csc_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [csc_pkg::RAD_W-1:0]    radicand,
	output logic                              busy,
	output logic [csc_pkg::ROOT_W-1:0]        root
);

	localparam int RAD_W  = csc_pkg::RAD_W;
	localparam int ROOT_W = csc_pkg::ROOT_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int CNT_W  = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// Bring down the next two radicand bits and try a one digit
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	// Control: start on go, count down the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath: restoring digit recurrence
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: rtl/core/csc_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on csc_pkg for the program and the control and status structs.
`default_nettype none

module csc_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire csc_pkg::seq_stat_t stat,
	output csc_pkg::ucode_t         ctrl,
	output logic                    ready
);

	logic [csc_pkg::UPC_W-1:0] pc_q;
	csc_pkg::ucode_t           word;
	logic                      take;

	// Fetch the control word of the current step
	assign word = csc_pkg::csc_ucode(pc_q);

	// Evaluate the jump condition
	always_comb begin
		case (word.cond)
			csc_pkg::CND_NEVER:     take = 1'b0;
			csc_pkg::CND_ALWAYS:    take = 1'b1;
			csc_pkg::CND_NO_ITEM:   take = !stat.item_valid;
			csc_pkg::CND_RUNNING:   take = stat.running;
			csc_pkg::CND_CAL_OPEN:  take = stat.cal_open;
			csc_pkg::CND_SQRT_BUSY: take = stat.sqrt_busy;
			csc_pkg::CND_WIN_OPEN:  take = stat.win_open;
			csc_pkg::CND_OUT_FULL:  take = stat.out_full;
			default:                take = 1'b0;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= csc_pkg::UA_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	assign ctrl  = word;
	assign ready = pc_q == csc_pkg::UA_IDLE;

`ifndef SYNTHESIS
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == csc_pkg::UA_IDLE && !stat.item_valid) |=> pc_q == csc_pkg::UA_IDLE)
		else $error("sequencer left idle without an item");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/csc_datapath.sv
// Datapath of the step counter: sample latch, shared multiplier, accumulator,
// calibration and window state, configuration registers and result register.
// Depends on csc_pkg and csc_sqrt.
`default_nettype none

module csc_datapath #(
	parameter int MAX_WINDOW = csc_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire csc_pkg::ucode_t                       ctrl,
	input  wire logic                                  sample_valid,
	input  wire logic                                  accept,
	input  wire logic signed [csc_pkg::ACCEL_BITS-1:0] accel_x,
	input  wire logic signed [csc_pkg::ACCEL_BITS-1:0] accel_y,
	input  wire logic                                  cfg_we,
	input  wire logic [csc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [csc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	output csc_pkg::seq_stat_t                         stat,
	input  wire logic                                  out_ready,
	output logic                                       out_valid,
	output logic [csc_pkg::COUNT_W-1:0]                step_count,
	output logic                                       step_taken,
	output logic                                       calibrating,
	output logic [csc_pkg::ROOT_W-1:0]                 threshold
);

	localparam int AB     = csc_pkg::ACCEL_BITS;
	localparam int MUL_W  = csc_pkg::MUL_W;
	localparam int PROD_W = csc_pkg::PROD_W;
	localparam int RAD_W  = csc_pkg::RAD_W;
	localparam int ROOT_W = csc_pkg::ROOT_W;
	localparam int CNT_W  = csc_pkg::COUNT_W;
	localparam int CAL_W  = csc_pkg::CAL_W;
	localparam int WL_W   = csc_pkg::WL_W;
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W  = (WL_W > LEN_W) ? WL_W : LEN_W;
	localparam int SUM_W  = $clog2(MAX_WINDOW * csc_pkg::MAG_MAX + 1);

	// Configuration registers
	logic [CAL_W-1:0] cal_samples_q;
	logic [WL_W-1:0]  win_len_q;

	// Item and calibration state
	logic signed [AB-1:0] x_q, y_q;
	logic signed [AB-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic                 in_cal_q;
	logic [CAL_W-1:0]     cal_cnt_q;
	logic [ROOT_W-1:0]    thr_q;
	logic [ROOT_W-1:0]    lo_q;

	// Arithmetic
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_full;
	logic [PROD_W-1:0]         prod_q;
	logic [RAD_W-1:0]          acc_q;

	// Window state
	logic [SUM_W-1:0]  sum_q;
	logic [LEN_W-1:0]  fill_q;
	logic [CNT_W-1:0]  steps_q;
	logic              step_q;

	// Result register
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_step_q;
	logic              out_cal_q;
	logic [ROOT_W-1:0] out_thr_q;

	logic              sqrt_busy;
	logic [ROOT_W-1:0] root;
	logic [CAL_W-1:0]  need;
	logic [CMP_W-1:0]  wl_ext, len_c;
	logic [LEN_W-1:0]  len;
	logic [ROOT_W:0]   thr_sum;
	logic              out_full;
	logic              emit_load;

	csc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ctrl.act == csc_pkg::ACT_SQRT),
		.radicand (acc_q),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// Effective calibration and window lengths
	always_comb begin
		need   = (cal_samples_q == '0) ? CAL_W'(1) : cal_samples_q;
		wl_ext = CMP_W'(win_len_q);
		if (wl_ext == '0) begin
			len_c = CMP_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			len_c = CMP_W'(MAX_WINDOW);
		end else begin
			len_c = wl_ext;
		end
		len     = len_c[LEN_W-1:0];
		thr_sum = (ROOT_W + 1)'(lo_q) + (ROOT_W + 1)'(root);
	end

	// Select multiplier operands: squares of coordinates, or threshold times length
	always_comb begin
		case (ctrl.mul_sel)
			csc_pkg::MS_X:    begin mul_a = MUL_W'(x_q);     mul_b = MUL_W'(x_q);     end
			csc_pkg::MS_Y:    begin mul_a = MUL_W'(y_q);     mul_b = MUL_W'(y_q);     end
			csc_pkg::MS_MINX: begin mul_a = MUL_W'(min_x_q); mul_b = MUL_W'(min_x_q); end
			csc_pkg::MS_MINY: begin mul_a = MUL_W'(min_y_q); mul_b = MUL_W'(min_y_q); end
			csc_pkg::MS_MAXX: begin mul_a = MUL_W'(max_x_q); mul_b = MUL_W'(max_x_q); end
			csc_pkg::MS_MAXY: begin mul_a = MUL_W'(max_y_q); mul_b = MUL_W'(max_y_q); end
			csc_pkg::MS_THR: begin
				mul_a = signed'(MUL_W'(thr_q));
				mul_b = signed'(MUL_W'(len));
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_full = mul_a * mul_b;
	end

	assign out_full  = out_valid_q && !out_ready;
	assign emit_load = (ctrl.act == csc_pkg::ACT_EMIT) && !out_full;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= csc_pkg::CAL_SAMPLES_RST;
			win_len_q     <= csc_pkg::WINDOW_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				csc_pkg::CFG_CAL_SAMPLES: cal_samples_q <= cfg_wdata[CAL_W-1:0];
				csc_pkg::CFG_WINDOW_LEN:  win_len_q     <= cfg_wdata[WL_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload: sample latch, product and accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= accel_x;
			y_q <= accel_y;
		end
		if (ctrl.mul_sel != csc_pkg::MS_NONE) begin
			prod_q <= mul_full[PROD_W-1:0];
		end
		case (ctrl.acc_op)
			csc_pkg::ACC_LOAD: acc_q <= prod_q;
			csc_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
			default: ;
		endcase
		if (ctrl.act == csc_pkg::ACT_SAVE_LO) begin
			lo_q <= root;
		end
	end

	// Calibration tracking, threshold, window and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cal_q  <= 1'b1;
			cal_cnt_q <= '0;
			min_x_q   <= csc_pkg::ACCEL_POS_MAX;
			min_y_q   <= csc_pkg::ACCEL_POS_MAX;
			max_x_q   <= csc_pkg::ACCEL_NEG_MAX;
			max_y_q   <= csc_pkg::ACCEL_NEG_MAX;
			thr_q     <= '0;
			sum_q     <= '0;
			fill_q    <= '0;
			steps_q   <= '0;
			step_q    <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= 1'b0;
			end
			case (ctrl.act)
				csc_pkg::ACT_TRACK: begin
					if (x_q > max_x_q) max_x_q <= x_q;
					if (x_q < min_x_q) min_x_q <= x_q;
					if (y_q > max_y_q) max_y_q <= y_q;
					if (y_q < min_y_q) min_y_q <= y_q;
					if (cal_cnt_q != '1) begin
						cal_cnt_q <= cal_cnt_q + 1'b1;
					end
				end
				csc_pkg::ACT_SET_THR: begin
					thr_q    <= thr_sum[ROOT_W:1];
					in_cal_q <= 1'b0;
				end
				csc_pkg::ACT_WIN_ADD: begin
					sum_q  <= sum_q + SUM_W'(root);
					fill_q <= fill_q + 1'b1;
				end
				csc_pkg::ACT_DECIDE: begin
					if (PROD_W'(sum_q) >= prod_q) begin
						step_q <= 1'b1;
						if (steps_q != '1) begin
							steps_q <= steps_q + 1'b1;
						end
					end
					sum_q  <= '0;
					fill_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_count_q <= steps_q;
			out_step_q  <= step_q;
			out_cal_q   <= in_cal_q;
			out_thr_q   <= thr_q;
		end
	end

	// Status back to the sequencer
	always_comb begin
		stat.item_valid = sample_valid;
		stat.running    = !in_cal_q;
		stat.cal_open   = cal_cnt_q < need;
		stat.sqrt_busy  = sqrt_busy;
		stat.win_open   = fill_q < len;
		stat.out_full   = out_full;
	end

	assign out_valid   = out_valid_q;
	assign step_count  = out_count_q;
	assign step_taken  = out_step_q;
	assign calibrating = out_cal_q;
	assign threshold   = out_thr_q;

`ifndef SYNTHESIS
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == csc_pkg::ACT_SQRT) |-> !sqrt_busy)
		else $error("square root started while busy");

	a_thr_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_cal_q) |-> ($stable(thr_q) && !in_cal_q))
		else $error("threshold changed after calibration");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.act == csc_pkg::ACT_EMIT))
		else $error("result raised outside the emit step");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == csc_pkg::ACT_DECIDE) |=> (sum_q == '0 && fill_q == '0))
		else $error("window not cleared after a decision");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/calibrated_step_counter.sv
// Calibrated step counter: top level, sequencer plus datapath.
// Depends on csc_pkg, csc_sample_if, csc_result_if, csc_sequencer, csc_datapath.
//
// Usage:
//   sample: valid/ready channel, one signed X/Y accelerometer sample per item.
//   result: valid/ready channel, exactly one item per sample (step_count,
//     step_taken, calibrating, threshold).
//   cfg_we/cfg_index/cfg_wdata: write-only registers, index 0 calibration
//     length, index 1 window length; write only while the block is idle.
// A calibration sample only updates the trackers and the sample count; the
// sample that ends calibration computes two magnitudes, and a counting sample
// one, followed by a decision step when it closes a window. Each magnitude
// waits on the 16-step iterative square root. Samples are taken one at a
// time: no new sample is accepted until the last one has left its emit step.
// The result sits in an output register; the next sample is accepted while it
// waits. A stalled receiver holds the sequencer in its emit step until the
// register frees, and no sample is taken meanwhile.
// Reset (arst_n low) returns to calibration with the register defaults, the
// min/max trackers at their extremes, and zero threshold, window and count.
`default_nettype none

module calibrated_step_counter #(
	parameter int MAX_WINDOW = csc_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	csc_sample_if.sink                          sample,
	csc_result_if.source                        result,
	input  wire logic                           cfg_we,
	input  wire logic [csc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [csc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	csc_pkg::ucode_t    ctrl;
	csc_pkg::seq_stat_t stat;
	logic               seq_ready;
	logic               accept;

	assign sample.ready = seq_ready;
	assign accept       = sample.valid && seq_ready;

	csc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.ready  (seq_ready)
	);

	csc_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sample_valid (sample.valid),
		.accept       (accept),
		.accel_x      (sample.accel_x),
		.accel_y      (sample.accel_y),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.stat         (stat),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.step_count   (result.step_count),
		.step_taken   (result.step_taken),
		.calibrating  (result.calibrating),
		.threshold    (result.threshold)
	);

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for calibrated_step_counter: drives X/Y samples, predicts
// each result item from its own model of calibration and step windows, and checks it.
// Depends on csc_pkg, csc_sample_if, csc_result_if and the calibrated_step_counter RTL.
`default_nettype none

module testbench;
	import csc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] step_count;
		logic               step_taken;
		logic               calibrating;
		logic [ROOT_W-1:0]  threshold;
	} step_report_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	csc_sample_if sample_ch ();
	csc_result_if result_ch ();

	calibrated_step_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block state and its registers
	logic                         pred_in_cal;
	logic [15:0]                  pred_cal_count;
	logic signed [ACCEL_BITS-1:0] pred_min_x, pred_max_x, pred_min_y, pred_max_y;
	logic [ROOT_W-1:0]            pred_threshold;
	logic [21:0]                  pred_win_sum;
	logic [6:0]                   pred_win_fill;
	logic [COUNT_W-1:0]           pred_steps;
	logic [CAL_W-1:0]             cal_len_reg;
	logic [WL_W-1:0]              win_len_reg;

	step_report_t expected_reports[$];
	int           mismatch_count = 0;
	bit           no_idle = 1'b0;

	// Append one prediction at the tail of the expected queue
	function automatic void append_report(input step_report_t rep);
		expected_reports = {expected_reports, rep};
	endfunction

	// Floored integer square root, two bits of the radicand per pass
	function automatic logic [ROOT_W-1:0] int_sqrt(input logic [RAD_W-1:0] radicand);
		logic [RAD_W-1:0] rem, root, probe;
		rem   = radicand;
		root  = '0;
		probe = {2'b01, {(RAD_W-2){1'b0}}};
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[ROOT_W-1:0];
	endfunction

	function automatic logic [ROOT_W-1:0] vector_magnitude(
			input logic signed [ACCEL_BITS-1:0] x, input logic signed [ACCEL_BITS-1:0] y);
		int               xs, ys;
		logic [RAD_W-1:0] xx, yy;
		xs = x;
		ys = y;
		xx = xs * xs;
		yy = ys * ys;
		return int_sqrt(xx + yy);
	endfunction

	// Advance the shadow state by one sample and return the result item it causes
	function automatic step_report_t predict_report(
			input logic signed [ACCEL_BITS-1:0] x, input logic signed [ACCEL_BITS-1:0] y);
		step_report_t    rep;
		int              need, len;
		logic [ROOT_W:0] pair_sum;
		logic            step;
		step = 1'b0;
		if (pred_in_cal) begin
			need = (cal_len_reg == 0) ? 1 : int'(cal_len_reg);
			if (x > pred_max_x) pred_max_x = x;
			if (x < pred_min_x) pred_min_x = x;
			if (y > pred_max_y) pred_max_y = y;
			if (y < pred_min_y) pred_min_y = y;
			if (pred_cal_count != 16'hFFFF)
				pred_cal_count = pred_cal_count + 1'b1;
			if (int'(pred_cal_count) >= need) begin
				pair_sum = vector_magnitude(pred_min_x, pred_min_y)
					+ vector_magnitude(pred_max_x, pred_max_y);
				pred_threshold = pair_sum[ROOT_W:1];
				pred_in_cal    = 1'b0;
			end
		end else begin
			len = (win_len_reg == 0) ? 1 : int'(win_len_reg);
			if (len > MAX_WINDOW_DEF)
				len = MAX_WINDOW_DEF;
			pred_win_sum  = pred_win_sum + vector_magnitude(x, y);
			pred_win_fill = pred_win_fill + 1'b1;
			if (int'(pred_win_fill) >= len) begin
				if (int'(pred_win_sum) >= int'(pred_threshold) * len) begin
					step = 1'b1;
					if (pred_steps != 16'hFFFF)
						pred_steps = pred_steps + 1'b1;
				end
				pred_win_sum  = '0;
				pred_win_fill = '0;
			end
		end
		rep.step_count  = pred_steps;
		rep.step_taken  = step;
		rep.calibrating = pred_in_cal;
		rep.threshold   = pred_threshold;
		return rep;
	endfunction

	// Send one sample item after a random gap; queue its prediction on accept
	task automatic send_sample(input logic signed [ACCEL_BITS-1:0] x,
			input logic signed [ACCEL_BITS-1:0] y);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		append_report(predict_report(x, y));
	endtask

	// Drop valid and hold until every outstanding result item has come back
	task automatic wait_drained();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CAL_SAMPLES)
			cal_len_reg = data;
		else if (idx == CFG_WINDOW_LEN)
			win_len_reg = data[WL_W-1:0];
	endtask

	// Pick a point whose magnitude lands close to the requested level
	task automatic make_sample_near(input int level,
			output logic signed [ACCEL_BITS-1:0] x, output logic signed [ACCEL_BITS-1:0] y);
		int a, b, reach;
		if (level > MAG_MAX) level = MAG_MAX;
		if (level < 0) level = 0;
		reach = (level > 32767) ? 32767 : level;
		a = $urandom_range(0, reach);
		b = int_sqrt(level * level - a * a);
		if (b > 32767) b = 32767;
		x = ACCEL_BITS'($urandom_range(0, 1) ? -a : a);
		y = ACCEL_BITS'($urandom_range(0, 1) ? -b : b);
	endtask

	// Calibration: min/max tracking, a lowered length, zero length ending it at once
	task automatic test_calibration();
		logic signed [ACCEL_BITS-1:0] rx, ry;
		write_reg(CFG_CAL_SAMPLES, 16'hFFFF);
		write_reg(CFG_WINDOW_LEN, 16'd64);
		send_sample(0, 0);
		send_sample(-1, -1);
		send_sample(1, -1);
		send_sample(12000, -9000);
		send_sample(-15000, 14000);
		send_sample(8000, 16000);
		repeat (30) begin
			rx = ACCEL_BITS'($urandom_range(0, 28000) - 14000);
			ry = ACCEL_BITS'($urandom_range(0, 28000) - 14000);
			send_sample(rx, ry);
		end
		wait_drained();
		write_reg(CFG_CAL_SAMPLES, 16'd40);
		send_sample(-2000, 500);
		send_sample(700, -3000);
		wait_drained();
		// Count is already past the new length: the next sample closes calibration
		write_reg(CFG_CAL_SAMPLES, 16'd0);
		send_sample(3000, 21000);
		wait_drained();
	endtask

	// Window edges: field extremes, exact threshold, lowered length, masked lengths
	task automatic test_window_edges();
		int                           boundary_x;
		logic signed [ACCEL_BITS-1:0] rx, ry;
		write_reg(CFG_WINDOW_LEN, 16'd1);
		send_sample(ACCEL_NEG_MAX, ACCEL_NEG_MAX);
		send_sample(ACCEL_POS_MAX, ACCEL_POS_MAX);
		send_sample(ACCEL_NEG_MAX, ACCEL_POS_MAX);
		send_sample(ACCEL_POS_MAX, ACCEL_NEG_MAX);
		send_sample(0, 0);
		// Magnitude equal to the threshold steps, one below does not
		boundary_x = (pred_threshold > 32767) ? 32767 : int'(pred_threshold);
		send_sample(ACCEL_BITS'(boundary_x), 0);
		send_sample(0, ACCEL_BITS'(-(boundary_x - 1)));
		wait_drained();
		write_reg(CFG_WINDOW_LEN, 16'd64);
		repeat (6) begin
			make_sample_near(pred_threshold, rx, ry);
			send_sample(rx, ry);
		end
		wait_drained();
		// Shorter than the current fill: the window closes on the next sample
		write_reg(CFG_WINDOW_LEN, 16'd3);
		repeat (4) begin
			make_sample_near(pred_threshold, rx, ry);
			send_sample(rx, ry);
		end
		wait_drained();
		write_reg(CFG_WINDOW_LEN, 16'd0);
		send_sample(-5, 3);
		send_sample(ACCEL_POS_MAX, 0);
		wait_drained();
		write_reg(CFG_WINDOW_LEN, 16'hFFFF);
		write_reg(CFG_CAL_SAMPLES, 16'd1);
	endtask

	// Random stream: mostly windows aimed near the threshold, some raw noise
	task automatic test_random_stream(input int total);
		int                           phase, n, per_phase, window_level, level, pick;
		logic [CFG_DATA_W-1:0]        win_choice, cal_choice;
		logic signed [ACCEL_BITS-1:0] rx, ry;
		per_phase    = total / 8;
		window_level = pred_threshold;
		for (phase = 0; phase < 8; phase++) begin
			wait_drained();
			case (phase)
				0:       win_choice = 16'd1;
				1:       win_choice = 16'd64;
				2:       win_choice = 16'hFFC5;
				3:       win_choice = CFG_DATA_W'($urandom_range(2, 8));
				4:       win_choice = CFG_DATA_W'($urandom_range(1, 64));
				5:       win_choice = 16'd0;
				6:       win_choice = CFG_DATA_W'($urandom_range(65, 127));
				default: win_choice = CFG_DATA_W'($urandom_range(1, 16));
			endcase
			case (phase % 3)
				0:       cal_choice = 16'hFFFF;
				1:       cal_choice = 16'd1;
				default: cal_choice = CFG_DATA_W'($urandom_range(0, 65535));
			endcase
			write_reg(CFG_WINDOW_LEN, win_choice);
			write_reg(CFG_CAL_SAMPLES, cal_choice);
			no_idle = ($urandom_range(0, 3) == 0);
			for (n = 0; n < per_phase; n++) begin
				// Choose a new target level at the start of each window
				if (pred_win_fill == 0)
					window_level = int'(pred_threshold) * $urandom_range(70, 130) / 100;
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					level = window_level + $urandom_range(0, window_level / 5 + 1)
						- window_level / 10;
					make_sample_near(level, rx, ry);
				end else if (pick < 95) begin
					rx = ACCEL_BITS'($urandom());
					ry = ACCEL_BITS'($urandom());
				end else begin
					case ($urandom_range(0, 3))
						0:       rx = ACCEL_NEG_MAX;
						1:       rx = ACCEL_POS_MAX;
						2:       rx = 0;
						default: rx = -1;
					endcase
					ry = $urandom_range(0, 1) ? ACCEL_NEG_MAX : ACCEL_POS_MAX;
				end
				send_sample(rx, ry);
				// Now and then hold the sender until the pipeline is empty
				if ($urandom_range(0, 199) == 0)
					wait_drained();
			end
		end
		no_idle = 1'b0;
	endtask

	// Result receiver: random stall before taking each item
	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
		end
	end

	// Compare each accepted result item with the oldest prediction
	always @(posedge clk) begin : check_reports
		step_report_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$error("result item arrived with no sample waiting for it");
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (result_ch.step_count !== want.step_count) begin
					$error("step_count: expected %0d, got %0d",
						want.step_count, result_ch.step_count);
					mismatch_count++;
				end
				if (result_ch.step_taken !== want.step_taken) begin
					$error("step_taken: expected %0d, got %0d",
						want.step_taken, result_ch.step_taken);
					mismatch_count++;
				end
				if (result_ch.calibrating !== want.calibrating) begin
					$error("calibrating: expected %0d, got %0d",
						want.calibrating, result_ch.calibrating);
					mismatch_count++;
				end
				if (result_ch.threshold !== want.threshold) begin
					$error("threshold: expected %0d, got %0d",
						want.threshold, result_ch.threshold);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: stop a hung run
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sample_ch.valid   = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		pred_in_cal       = 1'b1;
		pred_cal_count    = '0;
		pred_min_x        = ACCEL_POS_MAX;
		pred_min_y        = ACCEL_POS_MAX;
		pred_max_x        = ACCEL_NEG_MAX;
		pred_max_y        = ACCEL_NEG_MAX;
		pred_threshold    = '0;
		pred_win_sum      = '0;
		pred_win_fill     = '0;
		pred_steps        = '0;
		cal_len_reg       = CAL_SAMPLES_RST;
		win_len_reg       = WINDOW_LEN_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_calibration();
		test_window_edges();
		test_random_stream(1850);

		// Let the last result items out, then allow a worst-case latency more
		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
